### rtl/core/owbm_pkg.sv
package owbm_pkg;

  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned REG_W    = 10;
  localparam int unsigned IDX_W    = 3;

  localparam logic [IDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [IDX_W-1:0] REG_PRESENCE_TAIL = 3'd2;
  localparam logic [IDX_W-1:0] REG_WRITE_LOW     = 3'd3;
  localparam logic [IDX_W-1:0] REG_WRITE_HOLD    = 3'd4;
  localparam logic [IDX_W-1:0] REG_RECOVERY      = 3'd5;
  localparam logic [IDX_W-1:0] REG_READ_SAMPLE   = 3'd6;
  localparam logic [IDX_W-1:0] REG_READ_TAIL     = 3'd7;

  localparam logic [REG_W-1:0] RST_RESET_LOW     = 10'd600;
  localparam logic [REG_W-1:0] RST_PRESENCE_WAIT = 10'd30;
  localparam logic [REG_W-1:0] RST_PRESENCE_TAIL = 10'd200;
  localparam logic [REG_W-1:0] RST_WRITE_LOW     = 10'd5;
  localparam logic [REG_W-1:0] RST_WRITE_HOLD    = 10'd55;
  localparam logic [REG_W-1:0] RST_RECOVERY      = 10'd2;
  localparam logic [REG_W-1:0] RST_READ_SAMPLE   = 10'd15;
  localparam logic [REG_W-1:0] RST_READ_TAIL     = 10'd45;

  localparam logic [7:0] READ_MSB = 8'h80;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_TAIL = 4'd3,
    PH_WR_LOW   = 4'd4,
    PH_WR_HOLD  = 4'd5,
    PH_WR_REC   = 4'd6,
    PH_RD_REL   = 4'd7,
    PH_RD_LOW   = 4'd8,
    PH_RD_WAIT  = 4'd9,
    PH_RD_TAIL  = 4'd10
  } phase_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic       bus_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       presence;
  } out_item_t;

  typedef logic [NUM_REGS-1:0][REG_W-1:0] cfg_regs_t;

endpackage

### rtl/core/owbm_cfg_regs.sv
module owbm_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [owbm_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [owbm_pkg::REG_W-1:0]    cfg_wdata_i,
  output owbm_pkg::cfg_regs_t           regs_o
);

  owbm_pkg::cfg_regs_t regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q[owbm_pkg::REG_RESET_LOW]     <= owbm_pkg::RST_RESET_LOW;
      regs_q[owbm_pkg::REG_PRESENCE_WAIT] <= owbm_pkg::RST_PRESENCE_WAIT;
      regs_q[owbm_pkg::REG_PRESENCE_TAIL] <= owbm_pkg::RST_PRESENCE_TAIL;
      regs_q[owbm_pkg::REG_WRITE_LOW]     <= owbm_pkg::RST_WRITE_LOW;
      regs_q[owbm_pkg::REG_WRITE_HOLD]    <= owbm_pkg::RST_WRITE_HOLD;
      regs_q[owbm_pkg::REG_RECOVERY]      <= owbm_pkg::RST_RECOVERY;
      regs_q[owbm_pkg::REG_READ_SAMPLE]   <= owbm_pkg::RST_READ_SAMPLE;
      regs_q[owbm_pkg::REG_READ_TAIL]     <= owbm_pkg::RST_READ_TAIL;
    end else if (cfg_we_i) begin
      regs_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  assign regs_o = regs_q;

endmodule

### rtl/core/owbm_engine.sv
module owbm_engine #(
  parameter int unsigned TIMER_WIDTH = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  owbm_pkg::in_item_t    item_i,
  input  owbm_pkg::cfg_regs_t   regs_i,
  output owbm_pkg::out_item_t   result_o
);

  localparam int unsigned TW = TIMER_WIDTH;
  localparam int unsigned CW = (TW > owbm_pkg::REG_W) ? TW : owbm_pkg::REG_W;
  localparam logic [CW-1:0] TMAX_C = CW'((64'd1 << TW) - 64'd1);
  localparam logic [TW-1:0] ONE_T  = TW'(1);

  owbm_pkg::phase_e phase_q, phase_d, phase_s;
  logic [TW-1:0]    time_q, time_d, time_s, time_inc;
  logic [2:0]       bit_q, bit_d, bit_s;
  logic [7:0]       shift_q, shift_d, shift_s, shift_p;
  logic             pres_q, pres_d;
  logic [7:0]       rdata_q, rdata_d;
  logic             drive, busy, done;
  logic [owbm_pkg::IDX_W-1:0] dur_idx;
  logic [CW-1:0]    dur_ext, dur_sat;
  logic [TW-1:0]    dur;
  logic             fin;

  // Start of an operation and the sample taken on the first tail tick.
  always_comb begin
    phase_s = phase_q;
    time_s  = time_q;
    bit_s   = bit_q;
    shift_s = shift_q;
    if (phase_q == owbm_pkg::PH_IDLE && item_i.operation != owbm_pkg::OP_TICK) begin
      time_s  = '0;
      bit_s   = '0;
      shift_s = '0;
      case (item_i.operation)
        owbm_pkg::OP_RESET: phase_s = owbm_pkg::PH_RST_LOW;
        owbm_pkg::OP_WRITE: begin
          phase_s = owbm_pkg::PH_WR_LOW;
          shift_s = item_i.data_byte;
        end
        default: phase_s = owbm_pkg::PH_RD_REL;
      endcase
    end
    shift_p = shift_s;
    if (time_s == '0 && phase_s == owbm_pkg::PH_RD_TAIL) begin
      shift_p = (shift_s >> 1) | (item_i.bus_level ? owbm_pkg::READ_MSB : 8'h00);
    end
  end

  always_comb begin
    case (phase_s)
      owbm_pkg::PH_RST_LOW:  dur_idx = owbm_pkg::REG_RESET_LOW;
      owbm_pkg::PH_RST_WAIT: dur_idx = owbm_pkg::REG_PRESENCE_WAIT;
      owbm_pkg::PH_RST_TAIL: dur_idx = owbm_pkg::REG_PRESENCE_TAIL;
      owbm_pkg::PH_WR_LOW:   dur_idx = owbm_pkg::REG_WRITE_LOW;
      owbm_pkg::PH_WR_HOLD:  dur_idx = owbm_pkg::REG_WRITE_HOLD;
      owbm_pkg::PH_WR_REC,
      owbm_pkg::PH_RD_REL,
      owbm_pkg::PH_RD_LOW:   dur_idx = owbm_pkg::REG_RECOVERY;
      owbm_pkg::PH_RD_WAIT:  dur_idx = owbm_pkg::REG_READ_SAMPLE;
      default:               dur_idx = owbm_pkg::REG_READ_TAIL;
    endcase
    dur_ext = CW'(regs_i[dur_idx]);
    dur_sat = (dur_ext > TMAX_C) ? TMAX_C : dur_ext;
    dur     = (dur_sat[TW-1:0] == '0) ? ONE_T : dur_sat[TW-1:0];
    time_inc = time_s + ONE_T;
    fin      = (time_inc == '0) || (time_inc >= dur);
  end

  always_comb begin
    busy = (phase_s != owbm_pkg::PH_IDLE);
    case (phase_s)
      owbm_pkg::PH_RST_LOW,
      owbm_pkg::PH_WR_LOW,
      owbm_pkg::PH_RD_LOW:  drive = 1'b1;
      owbm_pkg::PH_WR_HOLD: drive = ~shift_s[0];
      default:              drive = 1'b0;
    endcase
  end

  always_comb begin
    phase_d = phase_s;
    time_d  = time_s;
    bit_d   = bit_s;
    shift_d = shift_p;
    pres_d  = pres_q;
    rdata_d = rdata_q;
    done    = 1'b0;
    if (time_s == '0 && phase_s == owbm_pkg::PH_RST_TAIL) begin
      pres_d = ~item_i.bus_level;
    end
    if (busy) begin
      time_d = time_inc;
      if (fin) begin
        time_d = '0;
        case (phase_s)
          owbm_pkg::PH_RST_LOW:  phase_d = owbm_pkg::PH_RST_WAIT;
          owbm_pkg::PH_RST_WAIT: phase_d = owbm_pkg::PH_RST_TAIL;
          owbm_pkg::PH_RST_TAIL: done = 1'b1;
          owbm_pkg::PH_WR_LOW:   phase_d = owbm_pkg::PH_WR_HOLD;
          owbm_pkg::PH_WR_HOLD:  phase_d = owbm_pkg::PH_WR_REC;
          owbm_pkg::PH_WR_REC: begin
            if (bit_s == 3'd7) begin
              done = 1'b1;
            end else begin
              bit_d   = bit_s + 3'd1;
              shift_d = shift_p >> 1;
              phase_d = owbm_pkg::PH_WR_LOW;
            end
          end
          owbm_pkg::PH_RD_REL:   phase_d = owbm_pkg::PH_RD_LOW;
          owbm_pkg::PH_RD_LOW:   phase_d = owbm_pkg::PH_RD_WAIT;
          owbm_pkg::PH_RD_WAIT:  phase_d = owbm_pkg::PH_RD_TAIL;
          default: begin
            if (bit_s == 3'd7) begin
              done    = 1'b1;
              rdata_d = shift_p;
            end else begin
              bit_d   = bit_s + 3'd1;
              phase_d = owbm_pkg::PH_RD_REL;
            end
          end
        endcase
        if (done) begin
          phase_d = owbm_pkg::PH_IDLE;
          bit_d   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= owbm_pkg::PH_IDLE;
      time_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      pres_q  <= 1'b0;
      rdata_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      time_q  <= time_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      pres_q  <= pres_d;
      rdata_q <= rdata_d;
    end
  end

  assign result_o.drive_low = drive;
  assign result_o.busy_res  = busy;
  assign result_o.done_res  = done;
  assign result_o.read_data = rdata_d;
  assign result_o.presence  = pres_d;

endmodule

### rtl/core/one_wire_bus_master_unit.sv
// Each input transfer yields one result, via the input and result registers.
// One input transfer is taken every cycle while in_stall_o is low; the bus state
// update for a tick is a single pass of logic between the input register and
// the result register. A stall on the result side holds the pipeline once both
// registers are full. Reset (rst_ni, asynchronous, active low) leaves the bus
// idle, the timing registers at their default values and both stages empty.
module one_wire_bus_master_unit #(
  parameter int unsigned TIMER_WIDTH = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  owbm_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output owbm_pkg::out_item_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [owbm_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [owbm_pkg::REG_W-1:0]    cfg_wdata_i
);

  owbm_pkg::cfg_regs_t regs;
  owbm_pkg::in_item_t  in_q;
  owbm_pkg::out_item_t result, out_q;
  logic                in_vld_q, out_vld_q;
  logic                out_hold, step, in_take;

  assign out_hold   = out_vld_q & out_stall_i;
  assign step       = in_vld_q & ~out_hold;
  assign in_stall_o = in_vld_q & out_hold;
  assign in_take    = in_valid_i & ~in_stall_o;

  owbm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .regs_o      (regs)
  );

  owbm_engine #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .regs_i   (regs),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (!out_hold) begin
        out_vld_q <= step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
